// File: hdl/dwrfc_pkg.sv
`default_nettype none

package dwrfc_pkg;

   // Table geometry
   localparam int WAYS      = 8;
   localparam int ROWS      = 256;
   localparam int KEY_BYTES = 13;

   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int KEY_W     = 104;
   localparam int CNT_W     = 32;
   localparam int KEY_BITS  = KEY_BYTES * 8;

   // Only the low KEY_BITS of the key are stored and compared
   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // Command codes
   localparam logic CMD_INCREMENT = 1'b0;
   localparam logic CMD_QUERY     = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  row;
      logic [63:0] key_low;
      logic [39:0] key_high;
      logic [31:0] random_value;
   } req_item_type;

   typedef struct packed {
      logic             hit;
      logic             admitted;
      logic [CNT_W-1:0] count;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic lookup;
      logic multiply;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic miss_increment;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/dwrfc_ctrl.sv
`default_nettype none

module dwrfc_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   output logic                   rsp_strobe,
   output dwrfc_pkg::ctrl_cmd_type cmd,
   input  dwrfc_pkg::dp_status_type status
);
   import dwrfc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_MULT   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff;

   // Decode commands from state
   always_comb begin
      cmd.load     = (state_ff == ST_IDLE) && start;
      cmd.lookup   = (state_ff == ST_LOOKUP);
      cmd.multiply = (state_ff == ST_MULT);
      cmd.commit   = (state_ff == ST_COMMIT);
   end

   // Advance state; skip the multiply step unless a miss needs admission
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = status.miss_increment ? ST_MULT : ST_COMMIT;
         end
         ST_MULT: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= cmd.commit;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;

endmodule

`default_nettype wire

// File: hdl/dwrfc_datapath.sv
`default_nettype none

module dwrfc_datapath (
   input  wire                      clock,
   input  wire                      reset,
   input  dwrfc_pkg::ctrl_cmd_type  cmd,
   input  dwrfc_pkg::req_item_type  req_item,
   output dwrfc_pkg::dp_status_type status,
   output dwrfc_pkg::rsp_item_type  rsp_item
);
   import dwrfc_pkg::*;

   localparam int LEVELS = (WAYS > 1) ? $clog2(WAYS) : 0;
   localparam int PAD    = 1 << LEVELS;

   typedef logic [WAYS-1:0][KEY_W-1:0] key_row_type;
   typedef logic [WAYS-1:0][CNT_W-1:0] cnt_row_type;

   // Row storage; counts are valid only in rows written since reset
   key_row_type   key_mem [ROWS];
   cnt_row_type   cnt_mem [ROWS];
   logic [ROWS-1:0] row_valid_ff;

   key_row_type   key_rd_ff;
   cnt_row_type   cnt_rd_ff;
   logic          rd_valid_ff;

   // Item held for the duration of its work
   logic                cmd_ff;
   logic [ROW_BITS-1:0] row_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [CNT_W-1:0]    random_ff;

   // Lookup results
   logic                hit_ff;
   logic [WAY_BITS-1:0] match_idx_ff;
   logic [CNT_W-1:0]    match_cnt_ff;
   logic [WAY_BITS-1:0] min_idx_ff;
   logic [CNT_W-1:0]    min_cnt_ff;
   logic [2*CNT_W-1:0]  product_ff;

   rsp_item_type        rsp_item_ff;

   logic [ROW_BITS-1:0] row_index;
   cnt_row_type         cnt_row;
   logic [WAYS-1:0]     match;
   logic                hit_in;
   logic [WAY_BITS-1:0] match_idx_in;
   logic [CNT_W-1:0]    lvl_cnt [LEVELS+1][PAD];
   logic [WAY_BITS-1:0] lvl_idx [LEVELS+1][PAD];

   logic                is_incr;
   logic                admit;
   logic [CNT_W-1:0]    base_cnt;
   logic [CNT_W-1:0]    new_cnt;
   logic [WAY_BITS-1:0] wr_idx;
   logic                wr_en;
   key_row_type         key_wr;
   cnt_row_type         cnt_wr;

   assign row_index = ROW_BITS'(req_item.row % ROWS);

   // Read the addressed row at accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_rd_ff <= key_mem[row_index];
         cnt_rd_ff <= cnt_mem[row_index];
      end
   end

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_item.cmd;
         row_ff    <= row_index;
         key_ff    <= {req_item.key_high, req_item.key_low} & KEY_MASK;
         random_ff <= req_item.random_value;
      end
   end

   // Hold row valid bits; an unwritten row reads as all-zero counts
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load) rd_valid_ff <= row_valid_ff[row_index];
         if (wr_en) row_valid_ff[row_ff] <= 1'b1;
      end
   end

   assign cnt_row = rd_valid_ff ? cnt_rd_ff : '0;

   // Compare keys in all ways; lowest matching way wins
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         match[w] = (cnt_row[w] != '0) && (key_rd_ff[w] == key_ff);
      end
      hit_in       = |match;
      match_idx_in = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) match_idx_in = WAY_BITS'(w);
      end
   end

   // Find the smallest count by a pairwise tree; ties keep the lower way
   always_comb begin
      for (int i = 0; i < PAD; i++) begin
         lvl_cnt[0][i] = (i < WAYS) ? cnt_row[i] : CNT_MAX;
         lvl_idx[0][i] = WAY_BITS'(i);
      end
      for (int l = 1; l <= LEVELS; l++) begin
         for (int i = 0; i < PAD; i++) begin
            lvl_cnt[l][i] = CNT_MAX;
            lvl_idx[l][i] = '0;
         end
         for (int i = 0; i < (PAD >> l); i++) begin
            if (lvl_cnt[l-1][2*i+1] < lvl_cnt[l-1][2*i]) begin
               lvl_cnt[l][i] = lvl_cnt[l-1][2*i+1];
               lvl_idx[l][i] = lvl_idx[l-1][2*i+1];
            end else begin
               lvl_cnt[l][i] = lvl_cnt[l-1][2*i];
               lvl_idx[l][i] = lvl_idx[l-1][2*i];
            end
         end
      end
   end

   assign status.miss_increment = !hit_in && (cmd_ff == CMD_INCREMENT);

   // Register lookup results
   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff       <= hit_in;
         match_idx_ff <= match_idx_in;
         match_cnt_ff <= cnt_row[match_idx_in];
         min_idx_ff   <= lvl_idx[LEVELS][0];
         min_cnt_ff   <= lvl_cnt[LEVELS][0];
      end
   end

   // Scale the smallest count by the random value
   always_ff @(posedge clock) begin
      if (cmd.multiply) begin
         product_ff <= (2*CNT_W)'(random_ff) * (2*CNT_W)'(min_cnt_ff);
      end
   end

   // Decide the update and the result
   always_comb begin
      is_incr  = (cmd_ff == CMD_INCREMENT);
      admit    = !hit_ff && is_incr &&
                 ((min_cnt_ff == '0) || (product_ff[2*CNT_W-1:CNT_W] == '0));
      base_cnt = hit_ff ? match_cnt_ff : min_cnt_ff;
      new_cnt  = (is_incr && (base_cnt != CNT_MAX)) ? base_cnt + CNT_W'(1) : base_cnt;
      wr_idx   = hit_ff ? match_idx_ff : min_idx_ff;
      wr_en    = cmd.commit && is_incr && (hit_ff || admit);

      key_wr = key_rd_ff;
      cnt_wr = cnt_row;
      if (!hit_ff) key_wr[wr_idx] = key_ff;
      cnt_wr[wr_idx] = new_cnt;
   end

   // Write back the row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[row_ff] <= key_wr;
         cnt_mem[row_ff] <= cnt_wr;
      end
   end

   // Hold the result for its strobe cycle
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_item_ff.hit      <= hit_ff;
         rsp_item_ff.admitted <= admit;
         rsp_item_ff.count    <= (hit_ff || admit) ? new_cnt : '0;
      end
   end

   assign rsp_item = rsp_item_ff;

endmodule

`default_nettype wire

// File: hdl/dway_rap_flow_counter_core.sv
`default_nettype none

// Set-associative flow counter with randomized admission. An item is taken
// when start is high and busy is low; its result appears on rsp_item for one
// cycle with rsp_strobe high and cannot be held off, so the receiver must take
// it then. Each item runs on its own: a hit or a query passes the lookup and
// commit states, an increment that misses also passes the multiply state, and
// the result strobes in the first cycle busy is low again. The steps are set
// by the single-port row memory (read the row, compare all ways and find the
// smallest count, write the row back) plus one 32x32 multiplier stage for the
// admission test on a miss. No clearing pass is needed after reset: a valid
// bit per row makes every count read as zero until its row is first written.

module dway_rap_flow_counter_core (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  dwrfc_pkg::req_item_type req_item,
   output logic                    rsp_strobe,
   output dwrfc_pkg::rsp_item_type rsp_item
);
   import dwrfc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   dwrfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   dwrfc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

   // A result never shows in the cycle right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("result strobed one cycle after accept");

   // A strobe closes the work of an item
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobed outside the end of an item");

   // Hit and admission exclude each other
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_item.hit && rsp_item.admitted))
      else $error("result both hit and admitted");

   // Found or admitted keys carry a nonzero count; others report zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_item.hit || rsp_item.admitted) == (rsp_item.count != '0)))
      else $error("result count disagrees with hit and admission");

endmodule

`default_nettype wire

// File: sim/tb_dway_rap_flow_counter_core.sv
`default_nettype none

module tb_dway_rap_flow_counter_core;

   import dwrfc_pkg::*;

   localparam int SLOTS      = ROWS * WAYS;
   localparam int HOT_ROWS   = 4;
   localparam int HOT_KEYS   = 12;
   localparam int RAND_ITEMS = 900;

   typedef struct {
      req_item_type item;
      int unsigned  gap;
      bit           drain;
   } pending_item_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   // Shadow copy of the flow table
   logic [KEY_W-1:0] flow_key_table   [SLOTS];
   logic [CNT_W-1:0] flow_count_table [SLOTS];

   pending_item_type pending_q[$];
   rsp_item_type     expected_rsp_q[$];
   int unsigned      gap_left   = 0;
   int unsigned      fail_count = 0;
   bit               idle_on    = 1'b1;

   logic [7:0]       hot_rows [HOT_ROWS];
   logic [KEY_W-1:0] hot_keys [HOT_ROWS][HOT_KEYS];

   dway_rap_flow_counter_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Update the shadow table for one item and return its result
   function automatic rsp_item_type predict_flow(req_item_type it);
      rsp_item_type     res;
      logic [KEY_W-1:0] key;
      int unsigned      base;
      int               match_way;
      int               min_way;
      logic [CNT_W-1:0] min_cnt;
      logic [63:0]      product;
      res       = '0;
      key       = {it.key_high, it.key_low} & KEY_MASK;
      base      = (int'(it.row) % ROWS) * WAYS;
      match_way = -1;
      // scan downward so the lowest matching way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (flow_count_table[base + w] != '0 && flow_key_table[base + w] == key)
            match_way = w;
      end
      if (match_way >= 0) begin
         res.hit = 1'b1;
         if (it.cmd == CMD_INCREMENT && flow_count_table[base + match_way] != CNT_MAX)
            flow_count_table[base + match_way] = flow_count_table[base + match_way] + 1'b1;
         res.count = flow_count_table[base + match_way];
      end else if (it.cmd == CMD_INCREMENT) begin
         min_way = 0;
         min_cnt = flow_count_table[base];
         for (int w = 1; w < WAYS; w++) begin
            if (flow_count_table[base + w] < min_cnt) begin
               min_cnt = flow_count_table[base + w];
               min_way = w;
            end
         end
         product = 64'(it.random_value) * 64'(min_cnt);
         // admit on an empty way or when the random draw passes
         if (min_cnt == '0 || product <= 64'(CNT_MAX)) begin
            flow_key_table[base + min_way] = key;
            if (min_cnt != CNT_MAX) min_cnt = min_cnt + 1'b1;
            flow_count_table[base + min_way] = min_cnt;
            res.admitted = 1'b1;
            res.count    = min_cnt;
         end
      end
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      logic [127:0] wide;
      wide = {$urandom, $urandom, $urandom, $urandom};
      return wide[KEY_W-1:0];
   endfunction

   // Mix of edge values, small values and values around the admission bound
   function automatic logic [31:0] random_draw();
      int unsigned k;
      case ($urandom_range(0, 3))
         0: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         1: return $urandom;
         2: return $urandom_range(0, 32'h3FFF_FFFF);
         default: begin
            k = $urandom_range(1, 16);
            return 32'hFFFF_FFFF / k + $urandom_range(0, 2) - 1;
         end
      endcase
   endfunction

   task automatic queue_item(input logic cmd, input logic [7:0] row,
                             input logic [KEY_W-1:0] key, input logic [31:0] draw,
                             input bit drain);
      pending_item_type p;
      p.item.cmd          = cmd;
      p.item.row          = row;
      p.item.key_low      = key[63:0];
      p.item.key_high     = key[KEY_W-1:64];
      p.item.random_value = draw;
      p.gap               = idle_on ? $urandom_range(0, 6) : 0;
      p.drain             = drain;
      pending_q.push_back(p);
   endtask

   // Driver: hold start until the item is taken, then idle and launch the next
   always @(posedge clock) begin : drive_proc
      pending_item_type next_item;
      logic             accepted;
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
         gap_left  = 0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            expected_rsp_q.push_back(predict_flow(req_item));
            gap_left = (pending_q.size() != 0) ? pending_q[0].gap : 0;
         end
         if (!start || accepted) begin
            if (gap_left != 0) begin
               gap_left = gap_left - 1;
               start <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && expected_rsp_q.size() != 0)) begin
               next_item = pending_q.pop_front();
               req_item <= next_item.item;
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each strobed result against the oldest expectation
   always @(posedge clock) begin : check_proc
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, got hit %0b admitted %0b count %0d",
                     $time, rsp_item.hit, rsp_item.admitted, rsp_item.count);
            fail_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_item.hit !== want.hit) begin
               $display("%0t: hit: expected %0b, got %0b", $time, want.hit, rsp_item.hit);
               fail_count++;
            end
            if (rsp_item.admitted !== want.admitted) begin
               $display("%0t: admitted: expected %0b, got %0b",
                        $time, want.admitted, rsp_item.admitted);
               fail_count++;
            end
            if (rsp_item.count !== want.count) begin
               $display("%0t: count: expected %0d, got %0d", $time, want.count, rsp_item.count);
               fail_count++;
            end
         end
      end
   end

   initial begin : stim_proc
      logic [KEY_W-1:0] row_keys [9];
      logic [KEY_W-1:0] key;
      logic             cmd;
      int unsigned      h;
      bit               drain;

      for (int s = 0; s < SLOTS; s++) begin
         flow_count_table[s] = '0;
         flow_key_table[s]   = '0;
      end
      for (int i = 0; i < 9; i++) row_keys[i] = random_key();

      // Directed: empty row, admission on empty ways, full-key compare
      queue_item(CMD_QUERY,     8'd0,   '0, 32'h0, 1'b0);
      queue_item(CMD_INCREMENT, 8'd0,   '0, 32'hFFFF_FFFF, 1'b0);
      queue_item(CMD_QUERY,     8'd0,   '0, 32'h0, 1'b0);
      queue_item(CMD_INCREMENT, 8'd255, '1, 32'h0, 1'b0);
      queue_item(CMD_QUERY,     8'd255, {1'b0, {(KEY_W-1){1'b1}}}, 32'h0, 1'b0);
      // fill one row, then bring every way to two
      for (int i = 0; i < 8; i++)
         queue_item(CMD_INCREMENT, 8'd7, row_keys[i], $urandom, 1'b0);
      for (int i = 0; i < 8; i++)
         queue_item(CMD_INCREMENT, 8'd7, row_keys[i], $urandom, 1'b0);
      // reject just over the bound, admit just under it, then see the eviction
      queue_item(CMD_INCREMENT, 8'd7, row_keys[8], 32'h8000_0000, 1'b0);
      queue_item(CMD_INCREMENT, 8'd7, row_keys[8], 32'h7FFF_FFFF, 1'b0);
      queue_item(CMD_QUERY,     8'd7, row_keys[0], 32'h0, 1'b0);

      // Hot rows with key pools larger than a row; half the keys differ by one bit
      for (int r = 0; r < HOT_ROWS; r++) begin
         hot_rows[r] = 8'($urandom_range(0, 255));
         for (int j = 0; j < HOT_KEYS / 2; j++) begin
            hot_keys[r][j] = random_key();
            hot_keys[r][j + HOT_KEYS / 2] = hot_keys[r][j] ^
                                            (KEY_W'(1) << $urandom_range(0, KEY_W - 1));
         end
      end

      // Random part: mostly traffic on hot rows, the rest scattered rows and keys
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
         drain = (n % 150 == 0);
         cmd   = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_INCREMENT;
         if ($urandom_range(0, 9) < 7) begin
            h   = $urandom_range(0, HOT_ROWS - 1);
            key = hot_keys[h][$urandom_range(0, HOT_KEYS - 1)];
            queue_item(cmd, hot_rows[h], key, random_draw(), drain);
         end else begin
            queue_item(cmd, 8'($urandom_range(0, 255)), random_key(), random_draw(), drain);
         end
      end

      // Release reset
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain everything, then let the block settle
      while (pending_q.size() != 0 || start) @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("dway_rap_flow_counter_core: match");
      else
         $display("dway_rap_flow_counter_core: mismatch");
      $finish;
   end

   // Watchdog
   initial begin
      #200000;
      $display("dway_rap_flow_counter_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
